FILE: src/gsa_pkg.sv
// Shared types and constants of the generational slot allocator.
package gsa_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_NOFREE  = 3'd2;
    localparam logic [2:0] ST_ALREADY = 3'd3;
    localparam logic [2:0] ST_STALE   = 3'd4;
    localparam logic [2:0] ST_ZERO    = 3'd5;

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int TAG_W   = 64;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 3;

    // The used map is stored as rows of 32 bits.
    localparam int ROW_BITS = 32;
    localparam int ROW_LW   = 5;

    // Width for comparing slot indexes against the pool size (up to 4096).
    localparam int CMP_W = 13;

    // Reset value of the slot limit register.
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: src/gsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/gsa_ctrl.sv
// Controller state machine of the generational slot allocator.
module gsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gsa_pkg::t_sts i_sts,
    output gsa_pkg::t_cmd o_cmd
);

    gsa_pkg::t_state r_state;
    gsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            gsa_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = gsa_pkg::S_READ;
                end
            end
            gsa_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = gsa_pkg::S_EVAL;
            end
            gsa_pkg::S_EVAL: begin
                // The result is committed only when the output register can take it.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = gsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/gsa_dp.sv
// Datapath of the generational slot allocator: map and tag memories, counters, result.
module gsa_dp #(
    parameter int SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gsa_pkg::t_cmd                 i_cmd,
    output gsa_pkg::t_sts                 o_sts,
    input  logic [gsa_pkg::KIND_W-1:0]    i_kind,
    input  logic [gsa_pkg::SLOT_W-1:0]    i_slot,
    input  logic [gsa_pkg::TAG_W-1:0]     i_expected_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gsa_pkg::STAT_W-1:0]    o_status,
    output logic [gsa_pkg::SLOT_W-1:0]    o_granted_slot,
    output logic [gsa_pkg::TAG_W-1:0]     o_granted_id,
    output logic                          o_matches_res,
    output logic [gsa_pkg::COUNT_W-1:0]   o_used_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gsa_pkg::COUNT_W-1:0]   i_cfg_slot_limit
);

    localparam int RB   = gsa_pkg::ROW_BITS;
    localparam int LW   = gsa_pkg::ROW_LW;
    localparam int CW   = gsa_pkg::CMP_W;
    localparam int ROWS = (SLOTS + RB - 1) / RB;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NROW = 2 ** RW;
    localparam int IW   = RW + LW;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    // Item registers.
    logic [gsa_pkg::KIND_W-1:0]  r_kind;
    logic [gsa_pkg::SLOT_W-1:0]  r_slot;
    logic [gsa_pkg::TAG_W-1:0]   r_exp;

    // Allocator state.
    logic [gsa_pkg::COUNT_W-1:0] r_limit;
    logic [gsa_pkg::COUNT_W-1:0] r_count;
    logic [gsa_pkg::TAG_W-1:0]   r_next_tag;
    logic [NROW-1:0]             r_row_full;
    logic [NROW-1:0]             r_row_valid;
    logic [RW-1:0]               r_row;
    logic                        r_row_found;

    // Output register.
    logic                        r_o_valid;
    logic [gsa_pkg::STAT_W-1:0]  r_status;
    logic [gsa_pkg::SLOT_W-1:0]  r_gslot;
    logic [gsa_pkg::TAG_W-1:0]   r_gid;
    logic                        r_match;
    logic [gsa_pkg::COUNT_W-1:0] r_used;

    logic [RW-1:0]               row_sel;
    logic                        row_any;
    logic [IW-1:0]               slot_ext;
    logic [RW-1:0]               rd_row;
    logic [RB-1:0]               map_rdata;
    logic [gsa_pkg::TAG_W-1:0]   tag_rdata;
    logic [RB-1:0]               word;
    logic [LW-1:0]               fbit;
    logic                        ffound;
    logic [IW-1:0]               acq_idx;
    logic [CW-1:0]               bound;
    logic                        pool_full;
    logic                        acq_ok;
    logic [LW-1:0]               sbit;
    logic                        used;
    logic                        slot_in;
    logic                        tag_hit;
    logic                        rel_ok;
    logic [gsa_pkg::STAT_W-1:0]  res_status;
    logic                        res_match;
    logic                        do_acq;
    logic                        do_rel;
    logic [RB-1:0]               new_word;
    logic                        out_free;

    // Lowest row that is not full.
    always_comb begin
        row_sel = '0;
        row_any = 1'b0;
        for (int r = NROW - 1; r >= 0; r--) begin
            if (!r_row_full[r]) begin
                row_sel = RW'(r);
                row_any = 1'b1;
            end
        end
    end

    assign slot_ext = IW'(r_slot);
    assign rd_row   = (r_kind == gsa_pkg::KIND_ACQUIRE) ? row_sel : slot_ext[IW-1:LW];

    // A row never written reads as all free.
    assign word = r_row_valid[r_row] ? map_rdata : '0;

    // Lowest free bit of the row.
    always_comb begin
        fbit   = '0;
        ffound = 1'b0;
        for (int b = RB - 1; b >= 0; b--) begin
            if (!word[b]) begin
                fbit   = LW'(b);
                ffound = 1'b1;
            end
        end
    end

    assign acq_idx   = {r_row, fbit};
    assign bound     = (CW'(r_limit) < SLOTS_C) ? CW'(r_limit) : SLOTS_C;
    assign pool_full = (r_count >= r_limit);
    assign acq_ok    = !pool_full && r_row_found && ffound && (CW'(acq_idx) < bound);

    assign sbit    = slot_ext[LW-1:0];
    assign used    = word[sbit];
    assign slot_in = (CW'(r_slot) < SLOTS_C);
    assign tag_hit = (tag_rdata == r_exp);
    assign rel_ok  = slot_in && used && tag_hit && (r_count != '0);

    always_comb begin
        res_status = gsa_pkg::ST_DONE;
        res_match  = 1'b0;
        new_word   = word;
        unique case (r_kind)
            gsa_pkg::KIND_ACQUIRE: begin
                new_word = word | (RB'(1) << fbit);
                if (pool_full) begin
                    res_status = gsa_pkg::ST_FULL;
                end else if (!acq_ok) begin
                    res_status = gsa_pkg::ST_NOFREE;
                end
            end
            gsa_pkg::KIND_RELEASE: begin
                new_word = word & ~(RB'(1) << sbit);
                if (!slot_in || !used) begin
                    res_status = gsa_pkg::ST_ALREADY;
                end else if (!tag_hit) begin
                    res_status = gsa_pkg::ST_STALE;
                end else if (r_count == '0) begin
                    res_status = gsa_pkg::ST_ZERO;
                end
            end
            gsa_pkg::KIND_QUERY: begin
                res_match = (CW'(r_slot) < bound) && used && tag_hit;
            end
            default: begin
                res_status = gsa_pkg::ST_DONE;
            end
        endcase
    end

    assign do_acq = i_cmd.commit && (r_kind == gsa_pkg::KIND_ACQUIRE) && acq_ok;
    assign do_rel = i_cmd.commit && (r_kind == gsa_pkg::KIND_RELEASE) && rel_ok;

    gsa_ram #(
        .WIDTH (RB),
        .DEPTH (NROW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (do_acq || do_rel),
        .i_waddr (r_row),
        .i_wdata (new_word),
        .i_re    (i_cmd.read),
        .i_raddr (rd_row),
        .o_rdata (map_rdata)
    );

    gsa_ram #(
        .WIDTH (gsa_pkg::TAG_W),
        .DEPTH (NROW * RB)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (do_acq),
        .i_waddr (acq_idx),
        .i_wdata (r_next_tag),
        .i_re    (i_cmd.read),
        .i_raddr (slot_ext),
        .o_rdata (tag_rdata)
    );

    assign out_free       = !r_o_valid || !i_out_stall;
    assign o_sts.out_free = out_free;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= gsa_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_next_tag  <= '0;
            r_row_full  <= '0;
            r_row_valid <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_slot_limit;
            end
            if (do_acq) begin
                r_count    <= r_count + 1'b1;
                r_next_tag <= r_next_tag + 1'b1;
            end else if (do_rel) begin
                r_count <= r_count - 1'b1;
            end
            if (do_acq || do_rel) begin
                r_row_full[r_row]  <= &new_word;
                r_row_valid[r_row] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_slot <= i_slot;
            r_exp  <= i_expected_id;
        end
        if (i_cmd.read) begin
            r_row       <= rd_row;
            r_row_found <= (r_kind == gsa_pkg::KIND_ACQUIRE) ? row_any : 1'b1;
        end
        if (i_cmd.commit) begin
            r_status <= res_status;
            r_gslot  <= do_acq ? gsa_pkg::SLOT_W'(acq_idx) : '0;
            r_gid    <= do_acq ? r_next_tag : '0;
            r_match  <= res_match;
            if (do_acq) begin
                r_used <= r_count + 1'b1;
            end else if (do_rel) begin
                r_used <= r_count - 1'b1;
            end else begin
                r_used <= r_count;
            end
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_o_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_gslot;
    assign o_granted_id   = r_gid;
    assign o_matches_res  = r_match;
    assign o_used_count   = r_used;

endmodule

FILE: src/generational_slot_allocator_unit.sv
// Top level of the generational slot allocator: controller, datapath and checks.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_kind, i_slot, i_expected_id
//   result    out        o_out_valid / i_out_stall  o_status, o_granted_slot,
//                                                   o_granted_id, o_matches_res,
//                                                   o_used_count
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_slot_limit
//
// An item is captured at the edge that accepts it. The used-map row and the tag are then
// read, with a single read of the map and tag memories per item. The result is then
// evaluated, written back and registered once the output register is free. The block
// accepts no new item until the current result has been committed.
// Reset clears the used map at once through per-row valid flags, so there is no
// clearing pass; the tag memory is not cleared. A stalled output only holds the
// evaluation step; a new item can still be accepted while a result waits to be taken.
module generational_slot_allocator_unit #(
    parameter int SLOTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gsa_pkg::KIND_W-1:0]    i_kind,
    input  logic [gsa_pkg::SLOT_W-1:0]    i_slot,
    input  logic [gsa_pkg::TAG_W-1:0]     i_expected_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gsa_pkg::STAT_W-1:0]    o_status,
    output logic [gsa_pkg::SLOT_W-1:0]    o_granted_slot,
    output logic [gsa_pkg::TAG_W-1:0]     o_granted_id,
    output logic                          o_matches_res,
    output logic [gsa_pkg::COUNT_W-1:0]   o_used_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gsa_pkg::COUNT_W-1:0]   i_cfg_slot_limit
);

    // Commands and status between the controller and the datapath.
    gsa_pkg::t_cmd cmd;
    gsa_pkg::t_sts sts;

    // The controller sequences each item through capture, memory read and evaluation.
    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the used map, the tags, the counters and the result register.
    gsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_slot           (i_slot),
        .i_expected_id    (i_expected_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_granted_slot   (o_granted_slot),
        .o_granted_id     (o_granted_id),
        .o_matches_res    (o_matches_res),
        .o_used_count     (o_used_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_slot_limit (i_cfg_slot_limit)
    );

    // A result is never committed over one that is still waiting to be taken.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result committed while the output register was occupied");

    // After an item is accepted, the block holds off the next one.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("a second item was accepted while one was in progress");

    // A committed result shows up at the output in the next cycle.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_valid)
        else $error("committed result did not appear at the output");

    // Only a successful acquire hands out a slot or a tag.
    a_grant_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != gsa_pkg::ST_DONE)) |->
        ((o_granted_id == '0) && (o_granted_slot == '0)))
        else $error("grant fields set on a failed operation");

endmodule
